[sv/rotated_span_rasterizer_top_defines.svh]
// Assertion macros shared by the rasterizer RTL.
`ifndef ROTATED_SPAN_RASTERIZER_TOP_DEFINES_SVH
`define ROTATED_SPAN_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rsr_pkg.sv]
`timescale 1ns / 1ps

package rsr_pkg;

  // Screen and shape limits
  localparam int SCREEN_SIZE = 96;
  localparam int MAX_RADIUS  = 31;

  // Widths that follow from the limits
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int SQ_W    = 2 * RAD_W;
  localparam int BIT_W   = (RAD_W > 1) ? $clog2(RAD_W) : 1;
  localparam int COORD_W = 10;

  // Field widths
  localparam int POS_W   = 7;
  localparam int COUNT_W = 14;
  localparam int COLOR_W = 16;
  localparam int ROT_W   = 2;

  // Rotation codes
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // Shape kinds
  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAD,
    ST_ROOT,
    ST_EMIT
  } state_t;

  // Request to the square root unit
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  // Answer from the square root unit
  typedef struct packed {
    logic             done;
    logic [RAD_W-1:0] root;
  } sqrt_rsp_t;

endpackage

[sv/rsr_sqrt.sv]
`timescale 1ns / 1ps

module rsr_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  rsr_pkg::sqrt_req_t req,
  output rsr_pkg::sqrt_rsp_t rsp
);
  import rsr_pkg::*;

  logic             running;
  logic             done;
  logic [BIT_W-1:0] bit_idx;
  logic [SQ_W-1:0]  value;
  logic [RAD_W-1:0] root;
  logic [RAD_W-1:0] trial;
  logic [SQ_W-1:0]  trial_sq;
  logic             fits;

  // Try the current bit: one square and one compare per cycle
  always_comb begin
    trial    = root | (RAD_W'(1) << bit_idx);
    trial_sq = SQ_W'(trial) * SQ_W'(trial);
    fits     = (trial_sq <= value);
  end

  // Sequence one result bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (req.start) begin
        running <= 1'b1;
        done    <= 1'b0;
      end else if (running && (bit_idx == '0)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end else begin
        done    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      value   <= req.radicand;
      root    <= '0;
      bit_idx <= BIT_W'(RAD_W - 1);
    end else if (running) begin
      if (fits) begin
        root <= trial;
      end
      if (bit_idx != '0) begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

[sv/rotated_span_rasterizer_top.sv]
`timescale 1ns / 1ps
// Rotated span rasterizer: turns one shape request into panel window beats.
// Command channel: a request is taken on a rising edge with start high and
// busy low. A rectangle (kind 0) gives one beat, a filled circle (kind 1)
// gives one single-row beat per row, from row y_pos+r up to row y_pos-r,
// 2r+1 beats with the radius saturated to 31. Each beat sits on
// the result ports for one cycle with done high; last marks the final beat.
// The receiver cannot stall, so beats go out as soon as they are ready.
// Order: a rectangle request goes straight to the emit state, and busy drops
// in the same cycle that its beat reaches the ports. Each circle row forms the
// radicand r*r - i*i, runs the five-bit bit-serial square root (one trial
// square and compare per result bit), hands the root off to build the window
// and then registers the window onto the ports.
// Every window is clamped to the 96x96 screen and mapped through the rotation
// register; the user writes it with cfg_write/cfg_data while idle (not enforced).
// Reset returns the sequencer to idle, drops done and sets the rotation to
// two-seventy degrees.

`include "rotated_span_rasterizer_top_defines.svh"

module rotated_span_rasterizer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [rsr_pkg::POS_W-1:0]      x_pos,
  input  logic [rsr_pkg::POS_W-1:0]      y_pos,
  input  logic [rsr_pkg::POS_W-1:0]      width_or_radius,
  input  logic [rsr_pkg::POS_W-1:0]      height,
  input  logic [rsr_pkg::COLOR_W-1:0]    color,
  input  logic                           cfg_write,
  input  logic [rsr_pkg::ROT_W-1:0]      cfg_data,
  output logic                           done,
  output logic [rsr_pkg::POS_W-1:0]      col_first,
  output logic [rsr_pkg::POS_W-1:0]      col_final,
  output logic [rsr_pkg::POS_W-1:0]      row_first,
  output logic [rsr_pkg::POS_W-1:0]      row_final,
  output logic [rsr_pkg::COUNT_W-1:0]    pixel_count,
  output logic [rsr_pkg::COLOR_W-1:0]    pixel_color,
  output logic                           off_screen,
  output logic                           last
);
  import rsr_pkg::*;

  localparam logic signed [COORD_W-1:0] S_MAX = COORD_W'(SCREEN_SIZE - 1);
  localparam logic [POS_W-1:0]          S_POS = POS_W'(SCREEN_SIZE - 1);

  state_t state, state_next;

  logic [ROT_W-1:0]          rotation;
  logic [POS_W-1:0]          x0, y0;
  logic [RAD_W-1:0]          radius;
  logic signed [RAD_W:0]     row_i;
  logic [COLOR_W-1:0]        fill;
  logic signed [COORD_W-1:0] wx1, wx2, wy1, wy2;
  logic                      w_nonempty, w_last;

  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  logic [RAD_W-1:0] row_abs;
  logic [RAD_W-1:0] rad_sat;

  // Clamp one bound to the screen
  function automatic logic [POS_W-1:0] clamp_axis(logic signed [COORD_W-1:0] v);
    logic [POS_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > S_MAX) begin
      c = S_POS;
    end else begin
      c = v[POS_W-1:0];
    end
    return c;
  endfunction

  rsr_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign busy    = (state != ST_IDLE);
  assign row_abs = (row_i < 0) ? RAD_W'(-row_i) : RAD_W'(row_i);
  assign rad_sat = (width_or_radius > POS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : RAD_W'(width_or_radius);

  // Sequencer: next state and square root request
  always_comb begin
    state_next        = state;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = SQ_W'(radius) * SQ_W'(radius) - SQ_W'(row_abs) * SQ_W'(row_abs);
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (kind == KIND_RECT) ? ST_EMIT : ST_RAD;
        end
      end
      ST_RAD: begin
        sqrt_req.start = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_next = w_last ? ST_IDLE : ST_RAD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the rotation register
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_270;
    end else if (cfg_write) begin
      rotation <= cfg_data;
    end
  end

  // Latch the request and build each unrotated window
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          x0     <= x_pos;
          y0     <= y_pos;
          fill   <= color;
          radius <= rad_sat;
          row_i  <= -$signed({1'b0, rad_sat});
          wx1    <= $signed(COORD_W'(x_pos));
          wy1    <= $signed(COORD_W'(y_pos));
          wx2    <= (width_or_radius != '0)
                    ? $signed(COORD_W'(x_pos) + COORD_W'(width_or_radius) - COORD_W'(1))
                    : $signed(COORD_W'(x_pos));
          wy2    <= (height != '0)
                    ? $signed(COORD_W'(y_pos) + COORD_W'(height) - COORD_W'(1))
                    : $signed(COORD_W'(y_pos));
          w_nonempty <= (width_or_radius != '0) && (height != '0);
          w_last     <= 1'b1;
        end
      end
      ST_ROOT: begin
        if (sqrt_rsp.done) begin
          wx1 <= $signed(COORD_W'(x0)) - $signed(COORD_W'(sqrt_rsp.root));
          wx2 <= $signed(COORD_W'(x0)) + $signed(COORD_W'(sqrt_rsp.root));
          wy1 <= $signed(COORD_W'(y0)) - COORD_W'(row_i);
          wy2 <= $signed(COORD_W'(y0)) - COORD_W'(row_i);
          w_nonempty <= 1'b1;
          w_last     <= (row_i == $signed({1'b0, radius}));
        end
      end
      ST_EMIT: begin
        row_i <= row_i + $signed((RAD_W+1)'(1));
      end
      default: begin
      end
    endcase
  end

  // Clamp, count and rotate the current window
  logic [POS_W-1:0]   cx1, cx2, cy1, cy2;
  logic [POS_W:0]     span_x, span_y;
  logic               w_off, w_vis;
  logic [2*POS_W+1:0] area;
  logic [POS_W-1:0]   c1, c2, r1, r2;

  always_comb begin
    cx1    = clamp_axis(wx1);
    cx2    = clamp_axis(wx2);
    cy1    = clamp_axis(wy1);
    cy2    = clamp_axis(wy2);
    w_off  = (wx1 < 0) || (wx2 > S_MAX) || (wy1 < 0) || (wy2 > S_MAX);
    w_vis  = w_nonempty && (wx2 >= 0) && (wx1 <= S_MAX) && (wy2 >= 0) && (wy1 <= S_MAX);
    span_x = {1'b0, cx2} - {1'b0, cx1} + (POS_W+1)'(1);
    span_y = {1'b0, cy2} - {1'b0, cy1} + (POS_W+1)'(1);
    area   = (2*POS_W+2)'(span_x) * (2*POS_W+2)'(span_y);
    case (rotation)
      ROT_0: begin
        c1 = cx1;         c2 = cx2;         r1 = cy1;         r2 = cy2;
      end
      ROT_90: begin
        c1 = S_POS - cy2; c2 = S_POS - cy1; r1 = cx1;         r2 = cx2;
      end
      ROT_180: begin
        c1 = S_POS - cx2; c2 = S_POS - cx1; r1 = S_POS - cy2; r2 = S_POS - cy1;
      end
      default: begin
        c1 = cy1;         c2 = cy2;         r1 = S_POS - cx2; r2 = S_POS - cx1;
      end
    endcase
  end

  // Drive one result beat per window
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      col_first   <= c1;
      col_final   <= c2;
      row_first   <= r1;
      row_final   <= r2;
      pixel_count <= w_vis ? area[COUNT_W-1:0] : '0;
      pixel_color <= fill;
      off_screen  <= w_off;
      last        <= w_last;
    end
  end

  // Checks on the sequencer and the result beats
  `RSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `RSR_ASSERT_SAME(a_more_rows, done && !last, busy, "beat without last while sequencer idle")
  `RSR_ASSERT_NEXT(a_emit_done, state == ST_EMIT, done, "window built but no beat strobed")
  `RSR_ASSERT_SAME(a_ordered, done, (col_first <= col_final) && (row_first <= row_final),
                   "window bounds out of order")

endmodule
